// File: rtl/core/cstok_pkg.sv
// Shared types, constants and character-class functions for the C subset token scanner.
package cstok_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int TOK_W             = 32;
    localparam int MAX_RES           = 3;
    localparam int RES_CNT_W         = 2;
    localparam int FIFO_DEPTH        = 4;
    localparam int KP_W              = 56;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    localparam logic [KP_W-1:0] KW_INT    = 56'h00_0000_0074_6e69;
    localparam logic [KP_W-1:0] KW_VOID   = 56'h00_0000_6469_6f76;
    localparam logic [KP_W-1:0] KW_RETURN = 56'h00_6e72_7574_6572;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_SLASH   = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    typedef enum logic [4:0] {
        K_LPAREN = 5'd0,
        K_RPAREN = 5'd1,
        K_LBRACE = 5'd2,
        K_RBRACE = 5'd3,
        K_COMMA  = 5'd4,
        K_DOT    = 5'd5,
        K_SEMI   = 5'd6,
        K_MINUS  = 5'd7,
        K_PLUS   = 5'd8,
        K_SLASH  = 5'd9,
        K_STAR   = 5'd10,
        K_IDENT  = 5'd11,
        K_NUMBER = 5'd12,
        K_INT    = 5'd13,
        K_VOID   = 5'd14,
        K_RETURN = 5'd15,
        K_END    = 5'd16,
        K_ERROR  = 5'd17
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic [TOK_W-1:0] line;
        logic             run_last;
    } t_tok;

    typedef struct packed {
        t_tok [MAX_RES-1:0]   tok;
        logic [RES_CNT_W-1:0] cnt;
    } t_tok_set;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_USCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == CH_NL) || (b == 8'h0D) ||
               (b == 8'h0B) || (b == 8'h0C);
    endfunction

    function automatic logic is_single(input logic [7:0] b);
        return (b == 8'h28) || (b == 8'h29) || (b == 8'h7B) || (b == 8'h7D) ||
               (b == 8'h2C) || (b == 8'h2E) || (b == 8'h3B) || (b == 8'h2D) ||
               (b == 8'h2B) || (b == 8'h2A);
    endfunction

    function automatic t_kind single_kind(input logic [7:0] b);
        t_kind k;
        unique case (b)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h2C:   k = K_COMMA;
            8'h2E:   k = K_DOT;
            8'h3B:   k = K_SEMI;
            8'h2D:   k = K_MINUS;
            8'h2B:   k = K_PLUS;
            8'h2A:   k = K_STAR;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/cstok_lexer.sv
// Scanner state and single-pass next-state and token logic, one source byte per cycle on i_fire.
module cstok_lexer #(
    parameter int POSITION_BITS = cstok_pkg::POSITION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output cstok_pkg::t_tok_set o_res
);
    import cstok_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_off, n_off;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_ps, n_ps;
    logic [POSITION_BITS-1:0] r_pl, n_pl;
    logic [POSITION_BITS-1:0] r_pln, n_pln;
    logic [KP_W-1:0]          r_kp, n_kp;

    t_tok                 cand [4];
    logic [3:0]           cv;
    logic [RES_CNT_W-1:0] cnt;
    logic                 used;
    logic                 nul_end;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic t_tok mk_tok(input t_kind k, input logic [POSITION_BITS-1:0] s,
                                    input logic [POSITION_BITS-1:0] l,
                                    input logic [POSITION_BITS-1:0] n);
        t_tok t;
        t.kind     = k;
        t.start    = TOK_W'(s);
        t.length   = TOK_W'(l);
        t.line     = TOK_W'(n);
        t.run_last = 1'b0;
        return t;
    endfunction

    // pending token as it would be flushed; valid only for ident, number, slash
    function automatic t_tok flush_tok(input t_mode m, input logic [POSITION_BITS-1:0] s,
                                       input logic [POSITION_BITS-1:0] l,
                                       input logic [POSITION_BITS-1:0] n,
                                       input logic [KP_W-1:0] kp);
        t_kind k;
        logic [POSITION_BITS-1:0] len;
        len = l;
        k   = K_IDENT;
        priority if (m == MODE_NUMBER) begin
            k = K_NUMBER;
        end else if (m == MODE_SLASH) begin
            k   = K_SLASH;
            len = POSITION_BITS'(1);
        end else if (l == POSITION_BITS'(3) && kp == KW_INT) begin
            k = K_INT;
        end else if (l == POSITION_BITS'(4) && kp == KW_VOID) begin
            k = K_VOID;
        end else if (l == POSITION_BITS'(6) && kp == KW_RETURN) begin
            k = K_RETURN;
        end else begin
            k = K_IDENT;
        end
        return mk_tok(k, s, len, n);
    endfunction

    function automatic logic has_pending(input t_mode m);
        return (m == MODE_IDENT) || (m == MODE_NUMBER) || (m == MODE_SLASH);
    endfunction

    always_comb begin
        n_mode  = r_mode;
        n_off   = r_off;
        n_line  = r_line;
        n_ps    = r_ps;
        n_pl    = r_pl;
        n_pln   = r_pln;
        n_kp    = r_kp;
        used    = 1'b0;
        nul_end = 1'b0;
        cv      = '0;
        for (int i = 0; i < 4; i++) begin
            cand[i] = '0;
        end

        unique case (r_mode)
            MODE_COMMENT: begin
                if (i_byte == CH_NUL || i_byte == CH_NL) begin
                    n_mode = MODE_IDLE;
                end else begin
                    used = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    n_mode = MODE_COMMENT;
                    used   = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_word(i_byte)) begin
                    if (r_pl[POSITION_BITS-1:3] == '0 && r_pl[2:0] != 3'd7) begin
                        n_kp = r_kp | (KP_W'(i_byte) << {r_pl[2:0], 3'b000});
                    end
                    n_pl = sat_inc(r_pl);
                    used = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(i_byte)) begin
                    n_pl = sat_inc(r_pl);
                    used = 1'b1;
                end
            end
            default: n_mode = MODE_IDLE;
        endcase

        if (has_pending(r_mode) && !used) begin
            cand[0] = flush_tok(r_mode, r_ps, r_pl, r_pln, r_kp);
            cv[0]   = 1'b1;
            n_mode  = MODE_IDLE;
            n_kp    = '0;
        end

        if (!used) begin
            priority if (i_byte == CH_NUL) begin
                nul_end = 1'b1;
            end else if (is_space(i_byte)) begin
                if (i_byte == CH_NL) begin
                    n_line = sat_inc(r_line);
                end
            end else if (is_single(i_byte)) begin
                cand[1] = mk_tok(single_kind(i_byte), r_off, POSITION_BITS'(1), r_line);
                cv[1]   = 1'b1;
            end else if (i_byte == CH_SLASH || is_digit(i_byte) || is_alpha(i_byte) ||
                         i_byte == CH_USCORE) begin
                n_mode = (i_byte == CH_SLASH) ? MODE_SLASH :
                         is_digit(i_byte)     ? MODE_NUMBER : MODE_IDENT;
                n_ps   = r_off;
                n_pl   = POSITION_BITS'(1);
                n_pln  = r_line;
                if (n_mode == MODE_IDENT) begin
                    n_kp = KP_W'(i_byte);
                end
            end else begin
                cand[1] = mk_tok(K_ERROR, r_off, POSITION_BITS'(1), r_line);
                cv[1]   = 1'b1;
            end
        end

        if (nul_end) begin
            cand[3] = mk_tok(K_END, r_off, '0, n_line);
            cv[3]   = 1'b1;
        end else begin
            n_off = sat_inc(r_off);
            if (i_last) begin
                if (has_pending(n_mode)) begin
                    cand[2] = flush_tok(n_mode, n_ps, n_pl, n_pln, n_kp);
                    cv[2]   = 1'b1;
                end
                cand[3] = mk_tok(K_END, n_off, '0, n_line);
                cv[3]   = 1'b1;
            end
        end

        if (nul_end || i_last) begin
            n_mode = MODE_IDLE;
            n_off  = '0;
            n_line = '0;
            n_ps   = '0;
            n_pl   = '0;
            n_pln  = '0;
            n_kp   = '0;
        end

        o_res = '0;
        cnt   = '0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i]) begin
                o_res.tok[cnt] = cand[i];
                cnt            = cnt + 1'b1;
            end
        end
        o_res.cnt = cnt;
        if (cnt != '0) begin
            o_res.tok[cnt - 1'b1].run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_off  <= '0;
            r_line <= '0;
            r_ps   <= '0;
            r_pl   <= '0;
            r_pln  <= '0;
            r_kp   <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_off  <= n_off;
            r_line <= n_line;
            r_ps   <= n_ps;
            r_pl   <= n_pl;
            r_pln  <= n_pln;
            r_kp   <= n_kp;
        end
    end

endmodule

// File: rtl/core/cstok_token_fifo.sv
// Small token queue: takes up to three tokens per cycle, hands out one per cycle.
module cstok_token_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cstok_pkg::t_tok_set i_set,
    input  logic                i_pop,
    output logic [$clog2(cstok_pkg::FIFO_DEPTH+1)-1:0] o_count,
    output cstok_pkg::t_tok     o_head
);
    import cstok_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_tok             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] push_n;

    assign push_n  = i_push ? CNT_W'(i_set.cnt) : '0;
    assign o_count = r_cnt;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(push_n)) begin
                r_mem[r_wr + PTR_W'(k)] <= i_set.tok[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(push_n);
            r_rd  <= r_rd + PTR_W'(i_pop);
            r_cnt <= r_cnt + push_n - CNT_W'(i_pop);
        end
    end

endmodule

// File: rtl/core/c_subset_token_scanner_top.sv
// Top level of the C subset token scanner: input register, lexer, token queue.
//
// Input channel: one source byte per word (i_in_byte, i_in_last) on i_valid/o_ready.
// A byte of 0 or a set i_in_last ends the text; the scanner then starts afresh at
// offset 0, line 0.
// Output channel: one token per word (kind, start, length, line, run_last) on
// o_valid/i_ready. A byte yields zero to three tokens; run_last marks the last
// token a byte produced.
// A byte is registered on accept, then scanned and its tokens written into the
// token queue once the queue has room; the queue head presents them in order.
// Throughput: one byte per cycle while each byte yields at most one token and the
// receiver takes tokens; the output port moves one token per cycle, so bytes that
// yield several tokens hold up the input. The four-entry token queue sets this.
// A byte is scanned only when the queue has room for all of its tokens, so a
// stalled receiver backs up into o_ready without losing anything.
// Reset (synchronous, active low) empties the queue and clears all scan state.
module c_subset_token_scanner_top #(
    parameter int POSITION_BITS = cstok_pkg::POSITION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_in_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [4:0]                   o_token_kind,
    output logic [cstok_pkg::TOK_W-1:0]  o_token_start,
    output logic [cstok_pkg::TOK_W-1:0]  o_token_length,
    output logic [cstok_pkg::TOK_W-1:0]  o_token_line,
    output logic                         o_run_last
);
    import cstok_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             r_in_vld;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             fire;
    logic             pop;
    logic [CNT_W-1:0] q_cnt;
    logic [CNT_W-1:0] room;
    t_tok_set         res;
    t_tok             head;

    assign pop     = o_valid && i_ready;
    assign room    = CNT_W'(FIFO_DEPTH) - q_cnt + CNT_W'(pop);
    assign fire    = r_in_vld && (CNT_W'(res.cnt) <= room);
    assign o_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_in_byte;
            r_last <= i_in_last;
        end
    end

    cstok_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_res   (res)
    );

    cstok_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_set   (res),
        .i_pop   (pop),
        .o_count (q_cnt),
        .o_head  (head)
    );

    assign o_valid        = (q_cnt != '0);
    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_token_line   = head.line;
    assign o_run_last     = head.run_last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("token queue overfilled");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_last || r_byte == CH_NUL) |-> res.cnt != '0)
        else $error("end of text produced no token");

    a_three_only_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.cnt == RES_CNT_W'(MAX_RES) |-> r_last)
        else $error("three tokens from a byte that is not last");

endmodule

// File: verif/testbench.sv
// Testbench for the C subset token scanner: byte stimulus, token prediction and checking.
`timescale 1ns / 100ps

module testbench;

    import cstok_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_token_kind;
    logic [31:0] o_token_start;
    logic [31:0] o_token_length;
    logic [31:0] o_token_line;
    logic        o_run_last;

    typedef struct {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] line_no;
        logic        run_last;
    } t_token;

    class t_token_scoreboard;
        t_mode            mode;
        logic [31:0]      offset;
        logic [31:0]      line_no;
        logic [31:0]      tok_start;
        logic [31:0]      tok_len;
        logic [31:0]      tok_line;
        logic [KP_W-1:0]  prefix;
        t_token           expected_tokens[$];
        int               mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode      = MODE_IDLE;
            offset    = '0;
            line_no   = '0;
            tok_start = '0;
            tok_len   = '0;
            tok_line  = '0;
            prefix    = '0;
        endfunction

        function logic [31:0] bump(input logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        function bit digit(input logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit letter(input logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit blank(input logic [7:0] b);
            case (b)
                8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit punct(input logic [7:0] b, output t_kind k);
            k = K_ERROR;
            case (b)
                "(": k = K_LPAREN;
                ")": k = K_RPAREN;
                "{": k = K_LBRACE;
                "}": k = K_RBRACE;
                ",": k = K_COMMA;
                ".": k = K_DOT;
                ";": k = K_SEMI;
                "-": k = K_MINUS;
                "+": k = K_PLUS;
                "*": k = K_STAR;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void add(ref t_token out[$], input t_kind k, input logic [31:0] s,
                          input logic [31:0] len, input logic [31:0] ln);
            t_token t;
            t.kind     = k;
            t.start    = s;
            t.length   = len;
            t.line_no  = ln;
            t.run_last = 1'b0;
            if (out.size() < MAX_RES) begin
                out.push_back(t);
            end
        endfunction

        function void open_token(input t_mode m);
            mode      = m;
            tok_start = offset;
            tok_len   = 32'd1;
            tok_line  = line_no;
        endfunction

        function void close_token(ref t_token out[$]);
            t_kind k;
            if (mode == MODE_IDENT) begin
                k = K_IDENT;
                if (tok_len == 3 && prefix == KW_INT) begin
                    k = K_INT;
                end else if (tok_len == 4 && prefix == KW_VOID) begin
                    k = K_VOID;
                end else if (tok_len == 6 && prefix == KW_RETURN) begin
                    k = K_RETURN;
                end
                add(out, k, tok_start, tok_len, tok_line);
            end else if (mode == MODE_NUMBER) begin
                add(out, K_NUMBER, tok_start, tok_len, tok_line);
            end else if (mode == MODE_SLASH) begin
                add(out, K_SLASH, tok_start, 32'd1, tok_line);
            end
            mode   = MODE_IDLE;
            prefix = '0;
        endfunction

        // Predict the tokens caused by one accepted word
        function void note_byte(input logic [7:0] b, input logic last);
            t_token out[$];
            bit     used;
            bit     nul_end;
            t_kind  k;
            used    = 1'b0;
            nul_end = 1'b0;
            case (mode)
                MODE_COMMENT: begin
                    if (b == CH_NUL || b == CH_NL) mode = MODE_IDLE;
                    else used = 1'b1;
                end
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        mode = MODE_COMMENT;
                        used = 1'b1;
                    end else begin
                        close_token(out);
                    end
                end
                MODE_IDENT: begin
                    if (letter(b) || digit(b) || b == CH_USCORE) begin
                        if (tok_len < 7) prefix = prefix | (KP_W'(b) << (8 * tok_len));
                        tok_len = bump(tok_len);
                        used    = 1'b1;
                    end else begin
                        close_token(out);
                    end
                end
                MODE_NUMBER: begin
                    if (digit(b)) begin
                        tok_len = bump(tok_len);
                        used    = 1'b1;
                    end else begin
                        close_token(out);
                    end
                end
                default: mode = MODE_IDLE;
            endcase
            if (!used) begin
                if (b == CH_NUL) begin
                    nul_end = 1'b1;
                end else if (blank(b)) begin
                    if (b == CH_NL) line_no = bump(line_no);
                end else if (punct(b, k)) begin
                    add(out, k, offset, 32'd1, line_no);
                end else if (b == CH_SLASH) begin
                    open_token(MODE_SLASH);
                end else if (digit(b)) begin
                    open_token(MODE_NUMBER);
                end else if (letter(b) || b == CH_USCORE) begin
                    open_token(MODE_IDENT);
                    prefix = KP_W'(b);
                end else begin
                    add(out, K_ERROR, offset, 32'd1, line_no);
                end
            end
            if (nul_end) begin
                add(out, K_END, offset, 32'd0, line_no);
                restart();
            end else begin
                offset = bump(offset);
                if (last) begin
                    if (mode == MODE_COMMENT) mode = MODE_IDLE;
                    close_token(out);
                    add(out, K_END, offset, 32'd0, line_no);
                    restart();
                end
            end
            if (out.size() > 0) out[out.size() - 1].run_last = 1'b1;
            foreach (out[i]) expected_tokens.push_back(out[i]);
        endfunction

        task report(input string msg);
            if (mismatches < 40) $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task check_token(input logic [4:0] kind, input logic [31:0] s,
                         input logic [31:0] len, input logic [31:0] ln, input logic rl);
            t_token e;
            if (expected_tokens.size() == 0) begin
                report($sformatf("unexpected token kind %0d start %0d", kind, s));
                return;
            end
            e = expected_tokens.pop_front();
            if (kind !== e.kind)
                report($sformatf("kind %0d, want %0d (start %0d)", kind, e.kind, e.start));
            if (s !== e.start)
                report($sformatf("start %0d, want %0d", s, e.start));
            if (len !== e.length)
                report($sformatf("length %0d, want %0d (start %0d)", len, e.length, e.start));
            if (ln !== e.line_no)
                report($sformatf("line %0d, want %0d (start %0d)", ln, e.line_no, e.start));
            if (rl !== e.run_last)
                report($sformatf("run_last %0b, want %0b (start %0d)", rl, e.run_last, e.start));
        endtask
    endclass

    t_token_scoreboard sb;

    logic [7:0] src_bytes[$];
    bit         src_last[$];
    bit         quiet;
    bit         bursty;

    c_subset_token_scanner_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_token_line   (o_token_line),
        .o_run_last     (o_run_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_byte(i_in_byte, i_in_last);
            if (o_valid && i_ready) begin
                sb.check_token(o_token_kind, o_token_start, o_token_length, o_token_line,
                               o_run_last);
            end
        end
    end

    // Receiver stalls in random bursts, with calm stretches in between
    int stall_left;
    int rx_cycles;
    always @(negedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && (rx_cycles / 120) % 3 != 0 && $urandom_range(0, 4) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit last);
        src_bytes.push_back(b);
        src_last.push_back(last);
    endtask

    task automatic push_str(input string s, input bit last);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], last && i == s.len() - 1);
    endtask

    task automatic add_random_lexeme();
        string       kw[3];
        string       near[9];
        logic [7:0]  spaces[6];
        logic [7:0]  puncts[10];
        logic [7:0]  c;
        int          pick;
        int          len;
        int          r;
        kw     = '{"int", "void", "return"};
        near   = '{"in", "intx", "voi", "voids", "retur", "returns", "Int", "_int", "return1"};
        spaces = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
        puncts = '{"(", ")", "{", "}", ",", ".", ";", "-", "+", "*"};
        pick   = $urandom_range(0, 99);
        if (pick < 12) begin
            push_str(kw[$urandom_range(0, 2)], 0);
        end else if (pick < 20) begin
            push_str(near[$urandom_range(0, 8)], 0);
        end else if (pick < 35) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, (i == 0) ? 52 : 62);
                if (r < 26) c = 8'(8'h61 + r);
                else if (r < 52) c = 8'(8'h41 + r - 26);
                else if (r == 52) c = CH_USCORE;
                else c = 8'(8'h30 + r - 53);
                push_byte(c, 0);
            end
        end else if (pick < 45) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) push_byte(8'(8'h30 + $urandom_range(0, 9)), 0);
        end else if (pick < 63) begin
            push_byte(puncts[$urandom_range(0, 9)], 0);
        end else if (pick < 68) begin
            push_byte(CH_SLASH, 0);
        end else if (pick < 73) begin
            push_str("//", 0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                c = 8'($urandom_range(1, 255));
                push_byte((c == CH_NL) ? 8'h78 : c, 0);
            end
            if ($urandom_range(0, 3) != 0) push_byte(CH_NL, 0);
        end else if (pick < 88) begin
            push_byte(spaces[$urandom_range(0, 5)], 0);
        end else if (pick < 94) begin
            push_byte(8'($urandom_range(1, 255)), 0);
        end else if (pick < 97 && src_last.size() > 0) begin
            src_last[src_last.size() - 1] = 1'b1;
        end else begin
            push_byte(CH_NUL, 1'($urandom_range(0, 1)));
        end
        if (pick < 45 && $urandom_range(0, 1) == 0) push_byte(8'h20, 0);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        @(negedge i_clk);
        if (!quiet && bursty && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_tokens.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int waited;
        sb        = new();
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_byte = 8'h00;
        i_in_last = 1'b0;
        i_ready   = 1'b0;
        quiet     = 1'b0;
        bursty    = 1'b1;
        rx_cycles = 0;
        stall_left = 0;

        push_str("int(void){return-9*+_,.;}", 1);
        push_byte(8'hFF, 0);
        push_str("/x//c", 1);
        push_byte(CH_NUL, 1);
        while (src_bytes.size() < 230) add_random_lexeme();
        src_last[src_last.size() - 1] = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        n = src_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            bursty = ((i / 30) % 2) == 0;
            quiet  = i >= n - 40;
            send_byte(src_bytes[i], src_last[i]);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        waited = 0;
        while (sb.expected_tokens.size() > 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.expected_tokens.size() > 0)
            sb.report($sformatf("%0d tokens never arrived", sb.expected_tokens.size()));

        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: c_subset_token_scanner_top.f
rtl/core/cstok_pkg.sv
rtl/core/cstok_lexer.sv
rtl/core/cstok_token_fifo.sv
rtl/core/c_subset_token_scanner_top.sv
verif/testbench.sv
